// ===== hw/rtl/wsd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the websocket frame deframer.
// Holds parse phases, opcodes, message type codes and the result item type.
// No dependencies.
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_SIZE    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASKKEY = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [2:0] MT_BINARY = 3'd0;
  localparam logic [2:0] MT_TEXT   = 3'd1;
  localparam logic [2:0] MT_PING   = 3'd2;
  localparam logic [2:0] MT_PONG   = 3'd3;
  localparam logic [2:0] MT_CLOSE  = 3'd4;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] HDR_EXT16 = 4'd2;
  localparam logic [3:0] HDR_EXT64 = 4'd8;
  localparam logic [3:0] HDR_MASK  = 4'd4;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        message_done;
    logic [2:0]  message_type;
    logic [15:0] close_code;
  } result_t;

endpackage

// ===== hw/rtl/wsd_if.sv =====
`timescale 1ns / 1ps
// Handshake channel interfaces for the websocket frame deframer.
// Depends on nothing beyond the package-free field widths.
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_out_if;
  logic        valid;
  logic        ready;
  logic        byte_valid;
  logic [7:0]  out_byte;
  logic        message_done;
  logic [2:0]  message_type;
  logic [15:0] close_code;

  modport source (output valid, output byte_valid, output out_byte, output message_done,
                  output message_type, output close_code, input ready);
  modport sink   (input valid, input byte_valid, input out_byte, input message_done,
                  input message_type, input close_code, output ready);
endinterface

// ===== hw/rtl/websocket_frame_deframer.sv =====
`timescale 1ns / 1ps
// Top level of the websocket frame deframer: input register, frame parser, result register.
// Depends on wsd_pkg, wsd_if, wsd_in_stage, wsd_parser and wsd_out_stage.
//
//  port   dir  carries
//  rx_i   in   rx_byte, one stream byte per item
//  tx_o   out  byte_valid, out_byte, message_done, message_type, close_code
//
// One byte per cycle sustained unless tx_o stalls; results are offered from a register.
// Non-final frame ends give no result; header bytes do only if ending a final empty frame.
// Reset clears the parser to expect an opcode byte; no clearing pass.
// A stalled result holds the parser and, once the input register fills, rx_i.ready.
module websocket_frame_deframer (
  input logic clk_i,
  input logic rst_ni,
  wsd_in_if.sink    rx_i,
  wsd_out_if.source tx_o
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             can_load;
  logic             advance;
  logic             res_valid;
  wsd_pkg::result_t res;
  wsd_pkg::result_t out_res;

  assign advance = in_valid && can_load;

  wsd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_byte_i  (rx_i.rx_byte),
    .in_ready_o (rx_i.ready),
    .advance_i  (advance),
    .valid_o    (in_valid),
    .byte_o     (in_byte)
  );

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsd_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && res_valid),
    .res_i      (res),
    .can_load_o (can_load),
    .valid_o    (tx_o.valid),
    .ready_i    (tx_o.ready),
    .res_o      (out_res)
  );

  assign tx_o.byte_valid   = out_res.byte_valid;
  assign tx_o.out_byte     = out_res.out_byte;
  assign tx_o.message_done = out_res.message_done;
  assign tx_o.message_type = out_res.message_type;
  assign tx_o.close_code   = out_res.close_code;

  a_result_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_o.valid |-> (tx_o.byte_valid || tx_o.message_done))
    else $error("result item carries neither byte nor report");

  a_close_code_only_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_o.valid && tx_o.close_code != 16'd0) |->
      (tx_o.message_done && tx_o.message_type == wsd_pkg::MT_CLOSE))
    else $error("close code outside a close report");

  a_in_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && !can_load) |=> (in_valid && $stable(in_byte)))
    else $error("input byte lost while result stalled");

endmodule

// ===== hw/rtl/wsd_in_stage.sv =====
`timescale 1ns / 1ps
// Input register of the websocket frame deframer.
// Holds one received byte until the parser consumes it. No package use.
module wsd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_ready_o,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== hw/rtl/wsd_parser.sv =====
`timescale 1ns / 1ps
// Frame parser of the websocket frame deframer: header walk, unmasking, message report.
// Depends on wsd_pkg.
module wsd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [7:0]       byte_i,
  output logic             res_valid_o,
  output wsd_pkg::result_t res_o
);

  wsd_pkg::phase_e phase_q, phase_d;
  logic        final_q, final_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_present_q, mask_present_d;
  logic [63:0] length_q, length_d;
  logic [3:0]  hdr_left_q, hdr_left_d;
  logic [31:0] mask_key_q, mask_key_d;
  logic [1:0]  mask_idx_q, mask_idx_d;
  logic [1:0]  seen_q, seen_d;
  logic [15:0] first_two_q, first_two_d;

  logic        len_known;
  logic        frame_end;
  logic [1:0]  byte_sel;
  logic [7:0]  plain;
  wsd_pkg::result_t res;

  assign byte_sel = ~mask_idx_q;
  assign plain    = byte_i ^ mask_key_q[{byte_sel, 3'b000} +: 8];

  always_comb begin
    phase_d        = phase_q;
    final_d        = final_q;
    opcode_d       = opcode_q;
    mask_present_d = mask_present_q;
    length_d       = length_q;
    hdr_left_d     = hdr_left_q;
    mask_key_d     = mask_key_q;
    mask_idx_d     = mask_idx_q;
    seen_d         = seen_q;
    first_two_d    = first_two_q;
    len_known      = 1'b0;
    frame_end      = 1'b0;
    res            = '0;
    if (advance_i) begin
      unique case (phase_q)
        wsd_pkg::PH_OPCODE: begin
          final_d = byte_i[7];
          if (byte_i[3:0] != wsd_pkg::OP_CONT) begin
            opcode_d    = byte_i[3:0];
            seen_d      = 2'd0;
            first_two_d = '0;
          end
          mask_key_d = '0;
          mask_idx_d = 2'd0;
          phase_d    = wsd_pkg::PH_SIZE;
        end
        wsd_pkg::PH_SIZE: begin
          mask_present_d = byte_i[7];
          length_d       = '0;
          if (byte_i[6:0] == wsd_pkg::LEN_EXT16) begin
            phase_d    = wsd_pkg::PH_EXTLEN;
            hdr_left_d = wsd_pkg::HDR_EXT16;
          end else if (byte_i[6:0] == wsd_pkg::LEN_EXT64) begin
            phase_d    = wsd_pkg::PH_EXTLEN;
            hdr_left_d = wsd_pkg::HDR_EXT64;
          end else begin
            length_d  = {57'd0, byte_i[6:0]};
            len_known = 1'b1;
          end
        end
        wsd_pkg::PH_EXTLEN: begin
          length_d   = {length_q[55:0], byte_i};
          hdr_left_d = hdr_left_q - 4'd1;
          len_known  = (hdr_left_d == 4'd0);
        end
        wsd_pkg::PH_MASKKEY: begin
          mask_key_d = {mask_key_q[23:0], byte_i};
          hdr_left_d = hdr_left_q - 4'd1;
          if (hdr_left_d == 4'd0) begin
            mask_present_d = 1'b0;
            len_known      = 1'b1;
          end
        end
        wsd_pkg::PH_PAYLOAD: begin
          res.byte_valid = 1'b1;
          res.out_byte   = plain;
          mask_idx_d     = mask_idx_q + 2'd1;
          if (seen_q != 2'd2) begin
            first_two_d = {first_two_q[7:0], plain};
            seen_d      = seen_q + 2'd1;
          end
          length_d  = length_q - 64'd1;
          frame_end = (length_d == 64'd0);
        end
        default: begin
          phase_d = wsd_pkg::PH_OPCODE;
        end
      endcase

      if (len_known) begin
        if (mask_present_d) begin
          phase_d    = wsd_pkg::PH_MASKKEY;
          hdr_left_d = wsd_pkg::HDR_MASK;
        end else if (length_d == 64'd0) begin
          frame_end = 1'b1;
        end else begin
          phase_d = wsd_pkg::PH_PAYLOAD;
        end
      end

      if (frame_end) begin
        phase_d = wsd_pkg::PH_OPCODE;
        if (final_q) begin
          res.message_done = 1'b1;
          unique case (opcode_q)
            wsd_pkg::OP_BINARY: res.message_type = wsd_pkg::MT_BINARY;
            wsd_pkg::OP_TEXT:   res.message_type = wsd_pkg::MT_TEXT;
            wsd_pkg::OP_PING:   res.message_type = wsd_pkg::MT_PING;
            wsd_pkg::OP_PONG:   res.message_type = wsd_pkg::MT_PONG;
            wsd_pkg::OP_CLOSE: begin
              res.message_type = wsd_pkg::MT_CLOSE;
              res.close_code   = (seen_d == 2'd2) ? first_two_d : 16'd0;
            end
            default: res.message_done = 1'b0;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= wsd_pkg::PH_OPCODE;
      final_q        <= 1'b0;
      opcode_q       <= 4'd0;
      mask_present_q <= 1'b0;
      length_q       <= '0;
      hdr_left_q     <= 4'd0;
      mask_key_q     <= '0;
      mask_idx_q     <= 2'd0;
      seen_q         <= 2'd0;
      first_two_q    <= '0;
    end else begin
      phase_q        <= phase_d;
      final_q        <= final_d;
      opcode_q       <= opcode_d;
      mask_present_q <= mask_present_d;
      length_q       <= length_d;
      hdr_left_q     <= hdr_left_d;
      mask_key_q     <= mask_key_d;
      mask_idx_q     <= mask_idx_d;
      seen_q         <= seen_d;
      first_two_q    <= first_two_d;
    end
  end

  assign res_valid_o = res.byte_valid || res.message_done;
  assign res_o       = res;

endmodule

// ===== hw/rtl/wsd_out_stage.sv =====
`timescale 1ns / 1ps
// Result register of the websocket frame deframer.
// Holds one result item until the sink takes it. Depends on wsd_pkg.
module wsd_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  wsd_pkg::result_t res_i,
  output logic             can_load_o,
  output logic             valid_o,
  input  logic             ready_i,
  output wsd_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  wsd_pkg::result_t res_q;

  assign can_load_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (can_load_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== test/tb_websocket_frame_deframer.sv =====
`timescale 1ns / 1ps
// Testbench for websocket_frame_deframer: feeds framed byte streams and checks each result item
// against a local frame parser. Depends on wsd_pkg, wsd_if and the deframer RTL.
module tb_websocket_frame_deframer;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni;

  wsd_in_if  rx_if ();
  wsd_out_if tx_if ();

  websocket_frame_deframer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .tx_o   (tx_if)
  );

  always #1 clk_i = ~clk_i;

  // parser state
  wsd_pkg::phase_e stream_phase;
  logic        frame_fin;
  logic [3:0]  msg_opcode;
  logic        key_pending;
  logic [63:0] bytes_left;
  logic [3:0]  hdr_left;
  logic [31:0] mask_key;
  logic [1:0]  key_pos;
  logic [1:0]  lead_count;
  logic [15:0] lead_bytes;
  logic        done_hit;
  logic [2:0]  done_kind;
  logic [15:0] done_code;

  wsd_pkg::result_t pending_results[$];
  wsd_pkg::result_t oldest;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;

  task automatic finish_frame();
    stream_phase = wsd_pkg::PH_OPCODE;
    if (frame_fin) begin
      done_hit = 1'b1;
      case (msg_opcode)
        wsd_pkg::OP_BINARY: done_kind = wsd_pkg::MT_BINARY;
        wsd_pkg::OP_TEXT:   done_kind = wsd_pkg::MT_TEXT;
        wsd_pkg::OP_PING:   done_kind = wsd_pkg::MT_PING;
        wsd_pkg::OP_PONG:   done_kind = wsd_pkg::MT_PONG;
        wsd_pkg::OP_CLOSE: begin
          done_kind = wsd_pkg::MT_CLOSE;
          done_code = (lead_count == 2'd2) ? lead_bytes : 16'h0000;
        end
        default: done_hit = 1'b0;
      endcase
    end
  endtask

  task automatic length_resolved();
    if (key_pending) begin
      stream_phase = wsd_pkg::PH_MASKKEY;
      hdr_left     = wsd_pkg::HDR_MASK;
    end else if (bytes_left == 64'd0) begin
      finish_frame();
    end else begin
      stream_phase = wsd_pkg::PH_PAYLOAD;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    wsd_pkg::result_t r;
    r         = '0;
    done_hit  = 1'b0;
    done_kind = '0;
    done_code = '0;
    case (stream_phase)
      wsd_pkg::PH_OPCODE: begin
        frame_fin = b[7];
        if (b[3:0] != wsd_pkg::OP_CONT) begin
          msg_opcode = b[3:0];
          lead_count = 2'd0;
          lead_bytes = 16'h0000;
        end
        mask_key     = '0;
        key_pos      = '0;
        stream_phase = wsd_pkg::PH_SIZE;
      end
      wsd_pkg::PH_SIZE: begin
        key_pending = b[7];
        bytes_left  = '0;
        if (b[6:0] == wsd_pkg::LEN_EXT16) begin
          stream_phase = wsd_pkg::PH_EXTLEN;
          hdr_left     = wsd_pkg::HDR_EXT16;
        end else if (b[6:0] == wsd_pkg::LEN_EXT64) begin
          stream_phase = wsd_pkg::PH_EXTLEN;
          hdr_left     = wsd_pkg::HDR_EXT64;
        end else begin
          bytes_left = 64'(b[6:0]);
          length_resolved();
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        bytes_left = {bytes_left[55:0], b};
        hdr_left   = hdr_left - 4'd1;
        if (hdr_left == 4'd0) length_resolved();
      end
      wsd_pkg::PH_MASKKEY: begin
        mask_key = {mask_key[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) begin
          key_pending = 1'b0;
          length_resolved();
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        r.byte_valid = 1'b1;
        r.out_byte   = b ^ mask_key[8 * (3 - key_pos) +: 8];
        key_pos      = key_pos + 2'd1;
        if (lead_count < 2'd2) begin
          lead_bytes = {lead_bytes[7:0], r.out_byte};
          lead_count = lead_count + 2'd1;
        end
        bytes_left = bytes_left - 64'd1;
        if (bytes_left == 64'd0) finish_frame();
      end
      default: stream_phase = wsd_pkg::PH_OPCODE;
    endcase
    if (r.byte_valid || done_hit) begin
      r.message_done = done_hit;
      r.message_type = done_hit ? done_kind : '0;
      r.close_code   = done_hit ? done_code : '0;
      pending_results = {pending_results, r};
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      rx_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    items_sent++;
    deframe_byte(b);
  endtask

  // form: 0 seven-bit length, 1 sixteen-bit, 2 sixty-four-bit
  task automatic send_frame(input logic [3:0] op, input logic fin, input logic masked,
                            input logic [63:0] len, input int unsigned form,
                            input int unsigned payload_bytes);
    send_byte({fin, 3'($urandom_range(7)), op});
    case (form)
      0: send_byte({masked, len[6:0]});
      1: begin
        send_byte({masked, wsd_pkg::LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, wsd_pkg::LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
    endcase
    if (masked) repeat (4) send_byte(8'($urandom_range(255)));
    repeat (payload_bytes) send_byte(8'($urandom_range(255)));
  endtask

  task automatic random_frame();
    logic [3:0]  op;
    int unsigned len;
    int unsigned form;
    int unsigned pick;
    case ($urandom_range(7))
      0, 1:    op = wsd_pkg::OP_CONT;
      2:       op = wsd_pkg::OP_TEXT;
      3:       op = wsd_pkg::OP_BINARY;
      4:       op = wsd_pkg::OP_CLOSE;
      5:       op = wsd_pkg::OP_PING;
      6:       op = wsd_pkg::OP_PONG;
      default: op = 4'($urandom_range(15));
    endcase
    pick = $urandom_range(9);
    if (pick < 7) begin
      form = 0;
      len  = ($urandom_range(3) == 0) ? $urandom_range(125) : $urandom_range(6);
    end else if (pick < 9) begin
      form = 1;
      len  = $urandom_range(300);
    end else begin
      form = 2;
      len  = $urandom_range(40);
    end
    send_frame(op, $urandom_range(3) != 0, 1'($urandom_range(1)), 64'(len), form, len);
  endtask

  // random bytes, then complete whatever frame they opened; extended lengths stay zero
  task automatic broken_frame();
    repeat ($urandom_range(1, 4))
      send_byte(stream_phase == wsd_pkg::PH_EXTLEN ? 8'h00 : 8'($urandom_range(255)));
    while (stream_phase != wsd_pkg::PH_OPCODE)
      send_byte(stream_phase == wsd_pkg::PH_EXTLEN ? 8'h00 : 8'($urandom_range(255)));
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  task automatic test_directed();
    logic [7:0] seq[$];
    send_idle_pct = 24;
    recv_idle_pct = 49;
    seq = '{8'h81, 8'h01, 8'h41,
            8'h82, 8'h80, 8'h12, 8'h34, 8'h56, 8'h78,
            8'h88, 8'h02, 8'h03, 8'hE8,
            8'h01, 8'h00, 8'h80, 8'h01, 8'hFF,
            8'hFF, 8'h7E, 8'h00, 8'h00,
            8'h89, 8'h00, 8'h8A, 8'h00};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_random_traffic(input int unsigned target, input int unsigned send_pct,
                                     input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (items_sent < target) begin
      if ($urandom_range(9) == 0) broken_frame();
      else random_frame();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 400;
    send_frame(wsd_pkg::OP_BINARY, 1'b1, 1'b1, 64'd150, 1, 150);
  endtask

  // length with the top bit set never completes, so leave it for the end
  task automatic test_endless_frame();
    logic [63:0] len;
    len = {1'b1, 31'($urandom()), 32'($urandom())};
    send_frame(wsd_pkg::OP_TEXT, 1'b1, 1'b1, len, 2, 30);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      tx_if.ready <= 1'b0;
    end else begin
      tx_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && tx_if.valid && tx_if.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: result with none expected, expected nothing, got byte 0x%0h done %0b",
                 $time, tx_if.out_byte, tx_if.message_done);
      end else begin
        oldest = pending_results.pop_front();
        check_field("byte_valid", 16'(oldest.byte_valid), 16'(tx_if.byte_valid));
        check_field("out_byte", 16'(oldest.out_byte), 16'(tx_if.out_byte));
        check_field("message_done", 16'(oldest.message_done), 16'(tx_if.message_done));
        check_field("message_type", 16'(oldest.message_type), 16'(tx_if.message_type));
        check_field("close_code", oldest.close_code, tx_if.close_code);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    stream_phase  = wsd_pkg::PH_OPCODE;
    frame_fin     = 1'b0;
    msg_opcode    = wsd_pkg::OP_CONT;
    key_pending   = 1'b0;
    bytes_left    = '0;
    hdr_left      = '0;
    mask_key      = '0;
    key_pos       = '0;
    lead_count    = '0;
    lead_bytes    = '0;
    rst_ni        <= 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(650, 24, 49);
    test_backpressure();
    test_random_traffic(1300, 49, 24);
    test_random_traffic(1900, 0, 0);
    test_endless_frame();

    rx_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
